@@ src/plp_pkg.sv @@
// Shared types and constants of the properties line parser.
// No dependencies; the front, queue, back, top level and testbench import this package.
package plp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  localparam logic [7:0] CH_EQUALS    = 8'h3D;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_HOLD,
    OP_CLEAR,
    OP_EMIT
  } plp_op_t;

  typedef struct packed {
    plp_op_t    op;
    logic [7:0] ch;
    logic       val;
    logic       rec;
    logic       com;
    logic       ovf;
  } plp_cmd_t;

  typedef enum logic {
    PH_WS,
    PH_TAIL
  } plp_phase_t;

endpackage

@@ src/plp_if.sv @@
// Handshake interfaces of the properties line parser: input bytes and results.
// Depends on nothing.
interface plp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       line_end;

  modport source (output valid, output in_char, output line_end, input ready);
  modport sink   (input valid, input in_char, input line_end, output ready);
endinterface

interface plp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       in_value;
  logic       record_end;
  logic       is_comment;
  logic       overflow;
  logic       last;

  modport source (output valid, output out_char, output in_value, output record_end,
                  output is_comment, output overflow, output last, input ready);
  modport sink   (input valid, input out_char, input in_value, input record_end,
                  input is_comment, input overflow, input last, output ready);
endinterface

@@ src/plp_front.sv @@
// Front part: accepts bytes, tracks line state and turns bytes into queue commands.
// Depends on plp_pkg.
module plp_front #(
  parameter int unsigned HOLD_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              line_end,
  input  logic              q_full,
  output logic              q_push,
  output plp_pkg::plp_cmd_t q_cmd
);
  import plp_pkg::*;

  localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);

  logic          key_started_r, key_started_nxt;
  logic          value_field_r, value_field_nxt;
  logic          escape_r, escape_nxt;
  logic          ignore_r, ignore_nxt;
  logic          raw_r, raw_nxt;
  logic          visible_r, visible_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          is_ws, is_sep, is_cmt, do_emit;
  plp_op_t       op;

  assign in_ready = !q_full;

  always_comb begin
    key_started_nxt = key_started_r;
    value_field_nxt = value_field_r;
    escape_nxt      = escape_r;
    ignore_nxt      = ignore_r;
    raw_nxt         = raw_r;
    visible_nxt     = visible_r;
    cnt_nxt         = cnt_r;
    ovf_nxt         = ovf_r;
    op              = OP_NONE;
    do_emit         = 1'b0;
    is_ws  = (in_char == CH_SPACE) || (in_char == CH_TAB);
    is_cmt = (in_char == CH_HASH) || (in_char == CH_BANG);
    is_sep = (in_char == CH_EQUALS) || (in_char == CH_COLON);

    if (!ignore_r) begin
      if (is_ws) begin
        if (key_started_r) begin
          escape_nxt = 1'b0;
          raw_nxt    = 1'b1;
          if (visible_r) begin
            if (cnt_r < DEPTH_C) begin
              op      = OP_HOLD;
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end else begin
        key_started_nxt = 1'b1;
        if (is_sep || is_cmt) begin
          if (escape_r) begin
            escape_nxt = 1'b0;
            do_emit    = 1'b1;
          end else if (is_cmt) begin
            if (!raw_r) begin
              ignore_nxt = 1'b1;
            end else begin
              do_emit = 1'b1;
            end
          end else if (value_field_r) begin
            do_emit = 1'b1;
          end else begin
            value_field_nxt = 1'b1;
            raw_nxt         = 1'b0;
            visible_nxt     = 1'b0;
            cnt_nxt         = '0;
            op              = OP_CLEAR;
          end
        end else if (in_char == CH_BACKSLASH) begin
          if (escape_r) begin
            escape_nxt = 1'b0;
            do_emit    = 1'b1;
          end else begin
            escape_nxt = 1'b1;
          end
        end else begin
          escape_nxt = 1'b0;
          do_emit    = 1'b1;
        end
      end
    end

    if (do_emit) begin
      op          = OP_EMIT;
      cnt_nxt     = '0;
      raw_nxt     = 1'b1;
      visible_nxt = 1'b1;
    end

    q_cmd.ch  = in_char;
    q_cmd.val = value_field_r;
    q_cmd.rec = line_end;
    q_cmd.com = ignore_nxt;
    q_cmd.ovf = ovf_nxt;
    if (line_end && op != OP_EMIT) begin
      q_cmd.op = OP_NONE;
    end else begin
      q_cmd.op = op;
    end
    q_push = in_valid && in_ready && ((op != OP_NONE) || line_end);

    if (line_end) begin
      key_started_nxt = 1'b0;
      value_field_nxt = 1'b0;
      escape_nxt      = 1'b0;
      ignore_nxt      = 1'b0;
      raw_nxt         = 1'b0;
      visible_nxt     = 1'b0;
      cnt_nxt         = '0;
      ovf_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_started_r <= 1'b0;
      value_field_r <= 1'b0;
      escape_r      <= 1'b0;
      ignore_r      <= 1'b0;
      raw_r         <= 1'b0;
      visible_r     <= 1'b0;
      cnt_r         <= '0;
      ovf_r         <= 1'b0;
    end else if (in_valid && in_ready) begin
      key_started_r <= key_started_nxt;
      value_field_r <= value_field_nxt;
      escape_r      <= escape_nxt;
      ignore_r      <= ignore_nxt;
      raw_r         <= raw_nxt;
      visible_r     <= visible_nxt;
      cnt_r         <= cnt_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

endmodule

@@ src/plp_queue.sv @@
// Short command queue between the front and back parts of the parser.
// Depends on plp_pkg.
module plp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  plp_pkg::plp_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output plp_pkg::plp_cmd_t head_cmd
);
  import plp_pkg::*;

  localparam int unsigned NW = QUEUE_AW + 1;

  plp_cmd_t            slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]       num_r;
  logic                do_push, do_pop;

  assign full       = (num_r == NW'(QUEUE_DEPTH));
  assign head_valid = (num_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      num_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        num_r <= num_r + NW'(1);
      end else if (do_pop && !do_push) begin
        num_r <= num_r - NW'(1);
      end
    end
  end

endmodule

@@ src/plp_back.sv @@
// Back part: keeps the held whitespace buffer and drives the result register.
// Depends on plp_pkg; takes commands from plp_queue.
module plp_back #(
  parameter int unsigned HOLD_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  plp_pkg::plp_cmd_t head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              in_value,
  output logic              record_end,
  output logic              is_comment,
  output logic              overflow,
  output logic              last
);
  import plp_pkg::*;

  localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  logic [7:0]    hold_mem [HOLD_DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  plp_phase_t    phase_r, phase_nxt;
  logic          out_v_r;
  logic          can_load, load, load_ws, done;
  logic [7:0]    ld_char;
  logic          ld_val, ld_rec, ld_com, ld_ovf, ld_last;

  assign can_load  = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign pop       = done;

  always_comb begin
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    load      = 1'b0;
    load_ws   = 1'b0;
    done      = 1'b0;
    ld_char   = head_cmd.ch;
    ld_val    = head_cmd.val;
    ld_rec    = 1'b0;
    ld_com    = 1'b0;
    ld_ovf    = 1'b0;
    ld_last   = 1'b0;
    if (head_valid) begin
      if (head_cmd.op == OP_EMIT && phase_r == PH_WS && idx_r < cnt_r) begin
        if (can_load) begin
          load    = 1'b1;
          load_ws = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end
      end else if (head_cmd.op == OP_EMIT && phase_r == PH_WS) begin
        if (can_load) begin
          load    = 1'b1;
          ld_last = !head_cmd.rec;
          if (head_cmd.rec) begin
            phase_nxt = PH_TAIL;
          end else begin
            done = 1'b1;
          end
        end
      end else if (head_cmd.rec) begin
        if (can_load) begin
          load    = 1'b1;
          ld_char = '0;
          ld_val  = 1'b0;
          ld_rec  = 1'b1;
          ld_com  = head_cmd.com;
          ld_ovf  = head_cmd.ovf;
          ld_last = 1'b1;
          done    = 1'b1;
        end
      end else begin
        done = 1'b1;
      end
    end
    if (done) begin
      idx_nxt   = '0;
      phase_nxt = PH_WS;
      if (head_cmd.op == OP_HOLD && !head_cmd.rec) begin
        cnt_nxt = cnt_r + CW'(1);
      end else begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      idx_r   <= '0;
      phase_r <= PH_WS;
      out_v_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done && head_cmd.op == OP_HOLD) begin
      hold_mem[cnt_r[AW-1:0]] <= head_cmd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (load_ws) begin
        out_char <= hold_mem[idx_r[AW-1:0]];
      end else begin
        out_char <= ld_char;
      end
      in_value   <= ld_val;
      record_end <= ld_rec;
      is_comment <= ld_com;
      overflow   <= ld_ovf;
      last       <= ld_last;
    end
  end

endmodule

@@ src/properties_line_parser.sv @@
// Top level of the properties line parser: front, command queue and back.
// Depends on plp_pkg, plp_if, plp_front, plp_queue and plp_back.
//
//   channel  | dir | beat
//   in_bus   | in  | in_char, line_end
//   out_bus  | out | out_char, in_value, record_end, is_comment, overflow, last
//
// The front takes one byte per cycle while the four-entry command queue has room.
// For a visible byte the back first sends each held blank, then the byte itself;
// a line end adds the record end as a result of its own. A held blank or a key
// separator is taken by the back without yielding a result.
// Reset is synchronous and clears all line state; there is no clearing pass.
// A stalled output holds the back, which fills the queue and then stalls input.
module properties_line_parser #(
  parameter int unsigned HOLD_DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  plp_in_if.sink    in_bus,
  plp_out_if.source out_bus
);
  import plp_pkg::*;

  logic     q_full, q_push, q_pop, q_head_valid;
  plp_cmd_t q_cmd, q_head;

  plp_front #(.HOLD_DEPTH(HOLD_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_char  (in_bus.in_char),
    .line_end (in_bus.line_end),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  plp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  plp_back #(.HOLD_DEPTH(HOLD_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_char   (out_bus.out_char),
    .in_value   (out_bus.in_value),
    .record_end (out_bus.record_end),
    .is_comment (out_bus.is_comment),
    .overflow   (out_bus.overflow),
    .last       (out_bus.last)
  );

endmodule

@@ src/plp_checker.sv @@
// Port-level checks of the properties line parser, bound to its top level.
// Depends only on the ports of properties_line_parser.
module plp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       in_value,
  input logic       record_end,
  input logic       is_comment,
  input logic       overflow,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
    else $error("Stalled result beat changed.");

  a_rec_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && record_end |-> last)
    else $error("Record end is not the last result of its byte.");

  a_rec_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && record_end |-> out_char == 8'h00 && !in_value)
    else $error("Record end carries a character.");

  a_flags_only_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !record_end |-> !is_comment && !overflow)
    else $error("Line flags set on a character beat.");

endmodule

bind properties_line_parser plp_checker u_plp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_char   (out_bus.out_char),
  .in_value   (out_bus.in_value),
  .record_end (out_bus.record_end),
  .is_comment (out_bus.is_comment),
  .overflow   (out_bus.overflow),
  .last       (out_bus.last)
);

@@ bench/properties_line_parser_tb.sv @@
// Self-checking testbench of properties_line_parser: directed and random lines.
// Depends on plp_pkg, plp_if and the parser RTL; a scoreboard predicts each beat.
`timescale 1ns / 100ps

module properties_line_parser_tb;
  import plp_pkg::*;

  localparam int HOLD_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_OFF     = 64;
  localparam int SETTLE       = 20;

  typedef logic [7:0] char_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       val;
    logic       rec;
    logic       com;
    logic       ovf;
    logic       last;
  } plp_beat_t;

  class plp_scoreboard;
    plp_beat_t expected_q[$];
    bit        key_started, value_field, escape_pending, ignore_rest;
    bit        raw_nonempty, field_visible, held_ovf;
    char_t     held_ws[HOLD_DEPTH];
    int        held_cnt;
    int        errors, beats_checked, lines_seen, comment_lines, overflow_lines;

    function void clear_line();
      key_started    = 0;
      value_field    = 0;
      escape_pending = 0;
      ignore_rest    = 0;
      raw_nonempty   = 0;
      field_visible  = 0;
      held_cnt       = 0;
      held_ovf       = 0;
    endfunction

    function void push_beat(char_t ch, bit val, bit rec, bit com, bit ovf);
      plp_beat_t b;
      b.ch   = ch;
      b.val  = val;
      b.rec  = rec;
      b.com  = com;
      b.ovf  = ovf;
      b.last = 1'b0;
      expected_q.push_back(b);
    endfunction

    // Held whitespace goes out only in front of a visible byte.
    function void emit_byte(char_t c);
      for (int i = 0; i < held_cnt; i++) push_beat(held_ws[i], value_field, 0, 0, 0);
      held_cnt = 0;
      push_beat(c, value_field, 0, 0, 0);
      raw_nonempty  = 1;
      field_visible = 1;
    endfunction

    function void note_byte(char_t c, logic le);
      int        n0;
      plp_beat_t tail;
      n0 = expected_q.size();
      if (!ignore_rest) begin
        if (c == CH_SPACE || c == CH_TAB) begin
          if (key_started) begin
            escape_pending = 0;
            raw_nonempty   = 1;
            if (field_visible) begin
              if (held_cnt < HOLD_DEPTH) begin
                held_ws[held_cnt] = c;
                held_cnt++;
              end else begin
                held_ovf = 1;
              end
            end
          end
        end else begin
          key_started = 1;
          if (c == CH_EQUALS || c == CH_COLON || c == CH_HASH || c == CH_BANG) begin
            if (escape_pending) begin
              escape_pending = 0;
              emit_byte(c);
            end else if (c == CH_HASH || c == CH_BANG) begin
              if (!raw_nonempty) ignore_rest = 1;
              else emit_byte(c);
            end else if (value_field) begin
              emit_byte(c);
            end else begin
              value_field   = 1;
              raw_nonempty  = 0;
              field_visible = 0;
              held_cnt      = 0;
            end
          end else if (c == CH_BACKSLASH) begin
            if (escape_pending) begin
              escape_pending = 0;
              emit_byte(c);
            end else begin
              escape_pending = 1;
            end
          end else begin
            escape_pending = 0;
            emit_byte(c);
          end
        end
      end
      if (le) begin
        push_beat(8'h00, 0, 1, ignore_rest, held_ovf);
        lines_seen++;
        if (ignore_rest) comment_lines++;
        if (held_ovf) overflow_lines++;
        clear_line();
      end
      if (expected_q.size() > n0) begin
        tail      = expected_q.pop_back();
        tail.last = 1'b1;
        expected_q.push_back(tail);
      end
    endfunction

    function void check_beat(plp_beat_t got);
      plp_beat_t exp_b;
      beats_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat char=%h val=%b rec=%b com=%b ovf=%b last=%b",
                 $time, got.ch, got.val, got.rec, got.com, got.ovf, got.last);
        return;
      end
      exp_b = expected_q.pop_front();
      if (got.ch !== exp_b.ch || got.val !== exp_b.val || got.rec !== exp_b.rec ||
          got.com !== exp_b.com || got.ovf !== exp_b.ovf || got.last !== exp_b.last) begin
        errors++;
        $display("%0t: mismatch expected char=%h val=%b rec=%b com=%b ovf=%b last=%b",
                 $time, exp_b.ch, exp_b.val, exp_b.rec, exp_b.com, exp_b.ovf, exp_b.last);
        $display("%0t:          actual   char=%h val=%b rec=%b com=%b ovf=%b last=%b",
                 $time, got.ch, got.val, got.rec, got.com, got.ovf, got.last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  plp_in_if  in_if ();
  plp_out_if out_if ();

  properties_line_parser #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if),
    .out_bus(out_if)
  );

  plp_scoreboard sb;
  int            items_sent;
  int            burst_left;
  bit            hold_req;
  int            hold_left;
  int            stall_mode;
  int            mode_left;
  char_t         line_q[$];

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("properties_line_parser_tb: FAIL");
    $finish;
  end

  // Receiver: checks each accepted beat and stalls on its own pattern.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_beat({out_if.out_char, out_if.in_value, out_if.record_end,
                     out_if.is_comment, out_if.overflow, out_if.last});
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 0;
      hold_left = HOLD_OFF - 1;
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: begin
          out_if.ready <= 1'b1;
        end
        1: begin
          out_if.ready <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          out_if.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  function automatic bit is_special(char_t c);
    return c == CH_SPACE || c == CH_TAB || c == CH_EQUALS || c == CH_COLON ||
           c == CH_HASH || c == CH_BANG || c == CH_BACKSLASH;
  endfunction

  function automatic char_t ordinary_char();
    char_t c;
    do c = char_t'($urandom_range(0, 255)); while (is_special(c));
    return c;
  endfunction

  function automatic char_t ws_char();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic char_t special_char();
    case ($urandom_range(0, 6))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_EQUALS;
      3: return CH_COLON;
      4: return CH_HASH;
      5: return CH_BANG;
      default: return CH_BACKSLASH;
    endcase
  endfunction

  function automatic char_t any_char();
    return $urandom_range(0, 1) ? char_t'($urandom_range(0, 255)) : special_char();
  endfunction

  function automatic void add_token(ref char_t q[$]);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      q.push_back(ordinary_char());
    end else if (r < 70) begin
      q.push_back(CH_BACKSLASH);
      q.push_back($urandom_range(0, 3) == 0 ? ordinary_char() : special_char());
    end else if (r < 90) begin
      repeat ($urandom_range(1, 3)) q.push_back(ws_char());
    end else begin
      q.push_back(special_char());
    end
  endfunction

  // Mostly well-formed key/value lines with random content, some comments and noise.
  function automatic void build_line(ref char_t q[$]);
    int r;
    q.delete();
    r = $urandom_range(0, 99);
    if (r < 15) begin
      repeat ($urandom_range(1, 8)) q.push_back(any_char());
    end else begin
      repeat ($urandom_range(0, 3)) q.push_back(ws_char());
      if (r < 27) begin
        q.push_back($urandom_range(0, 1) ? CH_HASH : CH_BANG);
        repeat ($urandom_range(0, 5)) q.push_back(any_char());
      end else begin
        repeat ($urandom_range(1, 5)) add_token(q);
        if ($urandom_range(0, 99) < 85) begin
          repeat ($urandom_range(0, 2)) q.push_back(ws_char());
          q.push_back($urandom_range(0, 1) ? CH_EQUALS : CH_COLON);
          repeat ($urandom_range(0, 2)) q.push_back(ws_char());
          if ($urandom_range(0, 99) < 8) q.push_back($urandom_range(0, 1) ? CH_HASH : CH_BANG);
          repeat ($urandom_range(0, 7)) add_token(q);
          if ($urandom_range(0, 99) < 20) begin
            q.push_back(ordinary_char());
            repeat ($urandom_range(14, 20)) q.push_back(ws_char());
            q.push_back(ordinary_char());
          end
        end
        repeat ($urandom_range(0, 3)) q.push_back(ws_char());
        if ($urandom_range(0, 99) < 10) q.push_back(CH_BACKSLASH);
      end
    end
    if (q.size() == 0) q.push_back(ws_char());
  endfunction

  // Offers one beat and returns once it is taken; gaps fall between bursts.
  task automatic send_byte(input char_t c, input logic le);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_if.valid    <= 1'b1;
    in_if.in_char  <= c;
    in_if.line_end <= le;
    do @(posedge clk); while (!in_if.ready);
    sb.note_byte(c, le);
    items_sent++;
    burst_left--;
  endtask

  task automatic send_line(input char_t q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    bit hold_done;
    bit pause_done;
    int target;
    sb             = new();
    sb.clear_line();
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_char  = 8'h00;
    in_if.line_end = 1'b0;
    out_if.ready   = 1'b0;
    hold_req       = 0;
    hold_left      = 0;
    mode_left      = 0;
    stall_mode     = 0;
    burst_left     = 0;
    items_sent     = 0;
    hold_done      = 0;
    pause_done     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A blank line holding only a tab.
    send_line('{CH_TAB});
    // Leading blank, escaped blank before the separator, backslash left at line end.
    send_line('{CH_SPACE, "k", CH_BACKSLASH, CH_SPACE, CH_COLON, "v", CH_BACKSLASH});
    // Comment opened by a bang; the hash after it is ignored.
    send_line('{CH_BANG, CH_HASH});
    // Escaped bang in the value, later separator literal, byte extremes.
    send_line('{"a", CH_COLON, CH_BACKSLASH, CH_BANG, CH_EQUALS, 8'hFF, 8'h00});
    // Value starting with a blank keeps the hash literal; double backslash gives one.
    send_line('{CH_EQUALS, CH_SPACE, CH_HASH, CH_BACKSLASH, CH_BACKSLASH, CH_SPACE, CH_BANG});

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if (!hold_done && items_sent >= target - 150) begin
        hold_req  = 1;
        hold_done = 1;
      end
      if (!pause_done && items_sent >= target - 70) begin
        wait_drained();
        burst_left = 0;
        pause_done = 1;
      end
      build_line(line_q);
      send_line(line_q);
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d bytes in %0d lines; %0d comment and %0d overflow records.",
             items_sent, sb.lines_seen, sb.comment_lines, sb.overflow_lines);
    $display("Checked %0d result beats with %0d errors.", sb.beats_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("properties_line_parser_tb: PASS");
    end else begin
      $display("properties_line_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
